### rtl/pal_pkg.sv
// pal_pkg: shared codes, widths and types for the positional array list.
// Used by pal_cell and positional_array_list. No dependencies.
package pal_pkg;

   // Default list capacity and the width of the count/position fields in cell commands
   localparam int CAPACITY_DEF = 32;
   localparam int CNT_W        = 7;

   // Request action codes
   localparam logic [1:0] ACT_INSERT   = 2'd0;
   localparam logic [1:0] ACT_DELETE   = 2'd1;
   localparam logic [1:0] ACT_TRAVERSE = 2'd2;

   // Response status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   // Cell operation codes
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic [1:0]       op;
      logic [CNT_W-1:0] pos_idx;   // zero-based target slot
      logic [CNT_W-1:0] fill;      // current element count
   } cell_cmd_type;

endpackage

### rtl/positional_array_list.sv
// positional_array_list: top level; request decode, fill count, traverse
// sequencer and a chain of pal_cell slots. Depends on pal_pkg and pal_cell.
//
// Insert, delete and unused action codes give one response each: the request is
// accepted when start is high and busy is low, and the single response appears
// on the rsp_ ports, with rsp_valid high, in the following cycle. Traverse of
// a list holding N elements gives N responses, one per cycle (one for an empty
// list); the chain rotates one slot per cycle toward slot 0 and is back
// in its original order after the last one, and busy is high while the later
// responses are produced. The receiver cannot stall: each response is valid
// for exactly one cycle and must be taken then. No clearing pass after reset.
module positional_array_list #(
   parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [5:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_element,
   output logic [5:0]         rsp_count,
   output logic               rsp_is_empty,
   output logic               rsp_last
);

   localparam int FW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = ((FW > 6) ? FW : 6) + 1;
   localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

   // Sequencer states
   localparam logic S_IDLE = 1'b0;
   localparam logic S_TRAV = 1'b1;

   logic                  state_ff,  state_in;
   logic [FW-1:0]         fill_ff,   fill_in;
   logic [FW-1:0]         rem_ff,    rem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic signed [31:0]    rsp_element_ff, rsp_element_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [5:0]            rsp_count_ff;
   logic                  rsp_is_empty_ff;

   pal_pkg::cell_cmd_type cmd;
   logic signed [31:0]    cell_data [CAPACITY];

   logic                  accept;
   logic [CW-1:0]         pos_ext;
   logic [CW-1:0]         fill_ext;
   logic                  ins_bad, ins_full, del_empty, del_bad;
   logic [pal_pkg::CNT_W-1:0] pos_idx;
   logic [IW-1:0]         rd_idx;

   assign accept   = start && (state_ff == S_IDLE);
   assign pos_ext  = CW'(req_position);
   assign fill_ext = CW'(fill_ff);
   assign pos_idx  = pal_pkg::CNT_W'(req_position) - 1'b1;
   assign rd_idx   = IW'(pos_idx);

   // Position and capacity checks
   assign ins_bad   = (pos_ext == '0) || (pos_ext > fill_ext + 1'b1);
   assign ins_full  = (fill_ext >= CAP_W);
   assign del_empty = (fill_ff == '0);
   assign del_bad   = (pos_ext == '0) || (pos_ext > fill_ext);

   // Request decode, chain command and response
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      rem_in         = rem_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = pal_pkg::ST_OK;
      rsp_element_in = '0;
      rsp_last_in    = 1'b1;
      cmd.op         = pal_pkg::CELL_HOLD;
      cmd.pos_idx    = pos_idx;
      cmd.fill       = pal_pkg::CNT_W'(fill_ff);
      if (state_ff == S_TRAV) begin
         rsp_valid_in   = 1'b1;
         rsp_element_in = cell_data[0];
         rsp_last_in    = (rem_ff == FW'(1));
         cmd.op         = pal_pkg::CELL_ROTATE;
         rem_in         = rem_ff - 1'b1;
         if (rem_ff == FW'(1)) begin
            state_in = S_IDLE;
         end
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         unique case (req_action)
            pal_pkg::ACT_INSERT: begin
               if (ins_bad) begin
                  rsp_status_in = pal_pkg::ST_BADPOS;
               end else if (ins_full) begin
                  rsp_status_in = pal_pkg::ST_FULL;
               end else begin
                  cmd.op  = pal_pkg::CELL_INSERT;
                  fill_in = fill_ff + 1'b1;
               end
            end
            pal_pkg::ACT_DELETE: begin
               if (del_empty) begin
                  rsp_status_in = pal_pkg::ST_EMPTY;
               end else if (del_bad) begin
                  rsp_status_in = pal_pkg::ST_BADPOS;
               end else begin
                  cmd.op         = pal_pkg::CELL_DELETE;
                  rsp_element_in = cell_data[rd_idx];
                  fill_in        = fill_ff - 1'b1;
               end
            end
            pal_pkg::ACT_TRAVERSE: begin
               if (del_empty) begin
                  rsp_status_in = pal_pkg::ST_EMPTY;
               end else begin
                  rsp_element_in = cell_data[0];
                  rsp_last_in    = (fill_ff == FW'(1));
                  cmd.op         = pal_pkg::CELL_ROTATE;
                  rem_in         = fill_ff - 1'b1;
                  if (fill_ff != FW'(1)) begin
                     state_in = S_TRAV;
                  end
               end
            end
            default: begin
               rsp_status_in = pal_pkg::ST_OK;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_status_ff   <= rsp_status_in;
      rsp_element_ff  <= rsp_element_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_count_ff    <= 6'(fill_in);
      rsp_is_empty_ff <= (fill_in == '0);
   end

   // Chain of slots
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_d;
      logic signed [31:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = cell_data[i];
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      pal_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .value      (req_value),
         .left_data  (left_d),
         .right_data (right_d),
         .head_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   assign busy         = (state_ff == S_TRAV);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_last     = rsp_last_ff;

   // Traverse emits a response in every busy cycle
   a_trav_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TRAV) |=> rsp_valid_ff)
      else $error("traverse cycle without response");

   // The final response of a request leaves the sequencer idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == S_IDLE))
      else $error("last response while traverse still running");

   // Fill never exceeds capacity
   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      (CW'(fill_ff) <= CAP_W))
      else $error("fill count above capacity");

   // Traverse never changes the fill count
   a_trav_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TRAV) |=> (fill_ff == $past(fill_ff)))
      else $error("fill changed during traverse");

   // Empty flag agrees with the count
   a_empty_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_is_empty_ff) |-> (rsp_count_ff == '0))
      else $error("empty flag with nonzero count");

endmodule

### rtl/pal_cell.sv
// pal_cell: one slot of the list chain; holds one element and takes its next
// value from itself, the request value, a neighbor or slot 0. Depends on pal_pkg.
module pal_cell #(
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  pal_pkg::cell_cmd_type      cmd,
   input  logic signed [31:0]         value,
   input  logic signed [31:0]         left_data,
   input  logic signed [31:0]         right_data,
   input  logic signed [31:0]         head_data,
   output logic signed [31:0]         data
);

   localparam logic [pal_pkg::CNT_W-1:0] MY_IDX = pal_pkg::CNT_W'(INDEX);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   // Next value: insert shifts up, delete shifts down, rotate walks toward slot 0
   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         pal_pkg::CELL_HOLD: begin
            data_in = data_ff;
         end
         pal_pkg::CELL_INSERT: begin
            if (MY_IDX == cmd.pos_idx) begin
               data_in = value;
            end else if (MY_IDX > cmd.pos_idx) begin
               data_in = left_data;
            end
         end
         pal_pkg::CELL_DELETE: begin
            if (MY_IDX >= cmd.pos_idx) begin
               data_in = right_data;
            end
         end
         pal_pkg::CELL_ROTATE: begin
            if (MY_IDX + 1'b1 < cmd.fill) begin
               data_in = right_data;
            end else if (MY_IDX + 1'b1 == cmd.fill) begin
               data_in = head_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Element storage, no reset: slots at or above the fill count are never read
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
